// File: rtl/btg_pkg.sv
// shared types and constants for the beep train generator
package btg_pkg;

  // field widths
  localparam int unsigned TimeW  = 16;
  localparam int unsigned CountW = 8;
  localparam int unsigned OpW    = 3;
  localparam int unsigned CfgIdxW = 1;

  // register reset values and the forever beep count
  localparam logic [TimeW-1:0]  OnTimeRst  = 16'd50;
  localparam logic [TimeW-1:0]  PeriodRst  = 16'd200;
  localparam logic [CountW-1:0] ForeverCnt = 8'hFF;

  // register indexes
  localparam logic [CfgIdxW-1:0] REG_ON_TIME = 1'b0;
  localparam logic [CfgIdxW-1:0] REG_PERIOD  = 1'b1;

  // operation codes
  localparam logic [OpW-1:0] OP_TICK      = 3'd0;
  localparam logic [OpW-1:0] OP_START     = 3'd1;
  localparam logic [OpW-1:0] OP_STOP      = 3'd2;
  localparam logic [OpW-1:0] OP_FORCE_ON  = 3'd3;
  localparam logic [OpW-1:0] OP_FORCE_OFF = 3'd4;

  // phase lengths derived from the registers
  typedef struct packed {
    logic [TimeW-1:0] on_len;
    logic [TimeW-1:0] off_len;
  } phase_len_t;

  // one result beat
  typedef struct packed {
    logic              level;
    logic              running;
    logic [CountW-1:0] left;
  } result_t;

endpackage

// File: rtl/btg_cfg.sv
// configuration registers and derived phase lengths
module btg_cfg
  import btg_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_we,
  input  logic [CfgIdxW-1:0] cfg_index,
  input  logic [TimeW-1:0]   cfg_wdata,
  output phase_len_t         len
);

  logic [TimeW-1:0] on_time_r;
  logic [TimeW-1:0] period_r;
  phase_len_t       len_r;
  phase_len_t       len_nxt;

  // register writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      on_time_r <= OnTimeRst;
      period_r  <= PeriodRst;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_ON_TIME: on_time_r <= cfg_wdata;
        REG_PERIOD:  period_r  <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // on phase is at least one tick, off phase at least one tick
  always_comb begin
    len_nxt.on_len = (on_time_r == '0) ? TimeW'(1) : on_time_r;
    if (period_r <= on_time_r) begin
      len_nxt.off_len = TimeW'(1);
    end else begin
      len_nxt.off_len = period_r - on_time_r;
    end
  end

  // lengths registered: a write lands in the config registers first, then here
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_r.on_len  <= OnTimeRst;
      len_r.off_len <= PeriodRst - OnTimeRst;
    end else begin
      len_r <= len_nxt;
    end
  end

  assign len = len_r;

endmodule

// File: rtl/btg_core.sv
// beep timer state and per-beat update
module btg_core
  import btg_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              fire,
  input  logic [OpW-1:0]    op,
  input  logic [CountW-1:0] count,
  input  phase_len_t        len,
  output result_t           res
);

  logic              level_r, level_nxt;
  logic              active_r, active_nxt;
  logic [TimeW-1:0]  tick_r, tick_nxt;
  logic [CountW-1:0] left_r, left_nxt;

  logic [TimeW:0]    tick_inc;
  logic [TimeW-1:0]  cur_len;
  logic              phase_done;
  logic [CountW-1:0] left_dec;

  // phase timing
  assign cur_len    = level_r ? len.on_len : len.off_len;
  assign tick_inc   = {1'b0, tick_r} + (TimeW+1)'(1);
  assign phase_done = (tick_inc >= {1'b0, cur_len});
  assign left_dec   = ((left_r == ForeverCnt) || (left_r == '0)) ? left_r
                                                                 : left_r - CountW'(1);

  // next state per operation
  always_comb begin
    level_nxt  = level_r;
    active_nxt = active_r;
    tick_nxt   = tick_r;
    left_nxt   = left_r;
    unique case (op)
      OP_TICK: begin
        if (active_r) begin
          if (phase_done) begin
            tick_nxt  = '0;
            level_nxt = !level_r;
            if (level_r) begin
              left_nxt = left_dec;
              if (left_dec == '0) begin
                active_nxt = 1'b0;
              end
            end
          end else begin
            tick_nxt = tick_inc[TimeW-1:0];
          end
        end
      end
      OP_START: begin
        left_nxt   = count;
        level_nxt  = 1'b1;
        active_nxt = 1'b1;
        tick_nxt   = '0;
      end
      OP_STOP, OP_FORCE_OFF: begin
        level_nxt  = 1'b0;
        active_nxt = 1'b0;
        tick_nxt   = '0;
      end
      OP_FORCE_ON: begin
        level_nxt  = 1'b1;
        active_nxt = 1'b0;
        tick_nxt   = '0;
      end
      default: ;
    endcase
  end

  // state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      level_r  <= 1'b0;
      active_r <= 1'b0;
      tick_r   <= '0;
      left_r   <= '0;
    end else if (fire) begin
      level_r  <= level_nxt;
      active_r <= active_nxt;
      tick_r   <= tick_nxt;
      left_r   <= left_nxt;
    end
  end

  assign res.level   = level_nxt;
  assign res.running = active_nxt;
  assign res.left    = left_nxt;

endmodule

// File: rtl/beep_train_generator.sv
// top level: input register, beep timer core, result register
//
//   channel | ports                                      | moves
//   in      | in_valid, in_stall, in_operation, in_beep_count | one command beat
//   out     | out_valid, out_stall, out_buzzer_level, out_running, out_beeps_left
//           |                                            | one result beat
//   cfg     | cfg_we, cfg_index, cfg_wdata               | one register write
//
// one beat per cycle unless out is stalled; a result goes from its input beat through
// the input register, then update logic into the result register
// reset clears the timer state and loads on_time 50, beep_period 200
// an out stall holds the result and backs up through the input register
// a register write is seen by beats accepted from the next cycle on
module beep_train_generator
  import btg_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [OpW-1:0]     in_operation,
  input  logic [CountW-1:0]  in_beep_count,
  output logic               out_valid,
  input  logic               out_stall,
  output logic               out_buzzer_level,
  output logic               out_running,
  output logic [CountW-1:0]  out_beeps_left,
  input  logic               cfg_we,
  input  logic [CfgIdxW-1:0] cfg_index,
  input  logic [TimeW-1:0]   cfg_wdata
);

  logic              in_vld_r;
  logic [OpW-1:0]    op_r;
  logic [CountW-1:0] cnt_r;
  logic              out_vld_r;
  result_t           res_r;
  result_t           res;
  phase_len_t        len;
  logic              adv;
  logic              in_take;

  // handshake
  assign adv      = in_vld_r && (!out_vld_r || !out_stall);
  assign in_stall = in_vld_r && !adv;
  assign in_take  = in_valid && !in_stall;

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_take) begin
      in_vld_r <= 1'b1;
    end else if (adv) begin
      in_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      op_r  <= in_operation;
      cnt_r <= in_beep_count;
    end
  end

  btg_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .len       (len)
  );

  btg_core u_core (
    .clk   (clk),
    .rst_n (rst_n),
    .fire  (adv),
    .op    (op_r),
    .count (cnt_r),
    .len   (len),
    .res   (res)
  );

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (adv) begin
      out_vld_r <= 1'b1;
    end else if (!out_stall) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      res_r <= res;
    end
  end

  assign out_valid        = out_vld_r;
  assign out_buzzer_level = res_r.level;
  assign out_running      = res_r.running;
  assign out_beeps_left   = res_r.left;

  // checks
  a_adv_fills: assert property (@(posedge clk) disable iff (!rst_n)
    adv |=> out_vld_r)
    else $error("result register not filled after advance");

  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (in_vld_r && out_vld_r && out_stall))
    else $error("input stalled without a blocked result");

  a_drain: assert property (@(posedge clk) disable iff (!rst_n)
    (out_vld_r && !out_stall && !in_vld_r) |=> !out_vld_r)
    else $error("result repeated after being taken");

  a_start: assert property (@(posedge clk) disable iff (!rst_n)
    (adv && (op_r == OP_START)) |=> (res_r.level && res_r.running))
    else $error("start did not turn the buzzer on");

endmodule
